@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, cond, expect_now, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |-> (expect_now)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, cond, expect_next, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cond) |=> (expect_next)) else $error(msg);

`endif

@@ rtl/bqc_pkg.sv @@
// ----------------------------------------------------------------------------
// Biquad cascade package
// Widths, formats, section state codes and the shared fixed-point helpers.
// ----------------------------------------------------------------------------
package bqc_pkg;

  // Structure of the cascade.
  localparam int NUM_SECTIONS   = 3;
  localparam int COEF_FRAC_BITS = 18;

  // Data formats.
  localparam int AUDIO_W       = 16;
  localparam int IN_FRAC_BITS  = 15;
  localparam int SIG_W         = 32;
  localparam int SIG_FRAC_BITS = 24;
  localparam int IN_SHIFT      = SIG_FRAC_BITS - IN_FRAC_BITS;

  // Coefficient register layout: b0, a1, a2 from the low end.
  localparam int COEF_W   = 20;
  localparam int CFG_W    = 3 * COEF_W;
  localparam int B0_LSB   = 0;
  localparam int A1_LSB   = COEF_W;
  localparam int A2_LSB   = 2 * COEF_W;

  localparam int CFG_IDX_W = $clog2(NUM_SECTIONS) + 1;

  // Product and accumulator widths.
  localparam int PROD_W = COEF_W + SIG_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef logic signed [SIG_W-1:0]   sig_t;
  typedef logic signed [AUDIO_W-1:0] audio_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // Section sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B,
    ST_SUM_Y,
    ST_MUL_A,
    ST_UPDATE
  } bqc_state_t;

  localparam acc_t ROUND_HALF = acc_t'(1) <<< (COEF_FRAC_BITS - 1);
  localparam acc_t SIG_MAX    = acc_t'({1'b0, {(SIG_W-1){1'b1}}});
  localparam acc_t SIG_MIN    = -SIG_MAX - acc_t'(1);

  localparam logic signed [SIG_W:0] OUT_HALF = (SIG_W+1)'(1) <<< (IN_SHIFT - 1);
  localparam logic signed [SIG_W:0] OUT_MAX  =
    (SIG_W+1)'({1'b0, {(AUDIO_W-1){1'b1}}});
  localparam logic signed [SIG_W:0] OUT_MIN  = -OUT_MAX - (SIG_W+1)'(1);

  // Round half up and drop the coefficient fraction bits.
  function automatic acc_t round_coef(input acc_t x);
    acc_t t;
    t = x + ROUND_HALF;
    return t >>> COEF_FRAC_BITS;
  endfunction

  // Saturate to the signed internal word.
  function automatic sig_t sat_sig(input acc_t x);
    sig_t r;
    if (x > SIG_MAX) begin
      r = sig_t'(SIG_MAX);
    end else if (x < SIG_MIN) begin
      r = sig_t'(SIG_MIN);
    end else begin
      r = sig_t'(x);
    end
    return r;
  endfunction

  // Round the internal word back to the audio format and saturate.
  function automatic audio_t to_audio(input sig_t y);
    logic signed [SIG_W:0] t;
    audio_t r;
    t = ((SIG_W+1)'(y) + OUT_HALF) >>> IN_SHIFT;
    if (t > OUT_MAX) begin
      r = audio_t'(OUT_MAX);
    end else if (t < OUT_MIN) begin
      r = audio_t'(OUT_MIN);
    end else begin
      r = audio_t'(t);
    end
    return r;
  endfunction

endpackage

@@ rtl/bqc_if.sv @@
// ----------------------------------------------------------------------------
// Biquad cascade channels
// Valid/ready channels for audio samples in and out and for register writes.
// ----------------------------------------------------------------------------

// Input sample channel.
interface bqc_in_if;
  logic                  valid;
  logic                  ready;
  bqc_pkg::audio_t       audio_in;

  modport source (output valid, output audio_in, input ready);
  modport sink   (input valid, input audio_in, output ready);
endinterface

// Filtered sample channel.
interface bqc_out_if;
  logic                  valid;
  logic                  ready;
  bqc_pkg::audio_t       audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink   (input valid, input audio_out, output ready);
endinterface

// Coefficient register write channel.
interface bqc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bqc_pkg::CFG_IDX_W-1:0]      index;
  logic [bqc_pkg::CFG_W-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/bqc_cell.sv @@
// ----------------------------------------------------------------------------
// Biquad section cell
// One transposed direct-form-II section with its own coefficients and two
// state words; takes a request from its left neighbor, hands it on right.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        coef_we,
  input  logic [bqc_pkg::CFG_W-1:0]   coef_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bqc_pkg::sig_t               in_sig,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bqc_pkg::sig_t               out_sig
);

  bqc_pkg::bqc_state_t       state_r, state_nxt;
  logic [bqc_pkg::CFG_W-1:0] coef_r;
  bqc_pkg::sig_t             d1_r, d2_r;
  bqc_pkg::sig_t             v_r, y_r, out_sig_r;
  bqc_pkg::prod_t            bv_r, pa1_r, pa2_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      in_fire, commit;
  logic                      at_update, busy, stalled;

  bqc_pkg::coef_t b0, a1, a2;
  bqc_pkg::acc_t  bv_ext, d1_sum, d2_sum;

  // Coefficient fields.
  assign b0 = bqc_pkg::coef_t'(coef_r[bqc_pkg::B0_LSB +: bqc_pkg::COEF_W]);
  assign a1 = bqc_pkg::coef_t'(coef_r[bqc_pkg::A1_LSB +: bqc_pkg::COEF_W]);
  assign a2 = bqc_pkg::coef_t'(coef_r[bqc_pkg::A2_LSB +: bqc_pkg::COEF_W]);

  // Handshake and step controls.
  always_comb begin
    commit   = (state_r == bqc_pkg::ST_UPDATE) && (!out_valid_r || out_ready);
    in_ready = (state_r == bqc_pkg::ST_IDLE) || commit;
    in_fire  = in_valid && in_ready;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Sequencer status for the checks below.
  assign at_update = (state_r == bqc_pkg::ST_UPDATE);
  assign busy      = (state_r == bqc_pkg::ST_MUL_B) || (state_r == bqc_pkg::ST_SUM_Y) ||
                     (state_r == bqc_pkg::ST_MUL_A);
  assign stalled   = at_update && !commit;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bqc_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = bqc_pkg::ST_MUL_B;
      end
      bqc_pkg::ST_MUL_B:  state_nxt = bqc_pkg::ST_SUM_Y;
      bqc_pkg::ST_SUM_Y:  state_nxt = bqc_pkg::ST_MUL_A;
      bqc_pkg::ST_MUL_A:  state_nxt = bqc_pkg::ST_UPDATE;
      bqc_pkg::ST_UPDATE: begin
        if (commit) state_nxt = in_fire ? bqc_pkg::ST_MUL_B : bqc_pkg::ST_IDLE;
      end
      default: state_nxt = bqc_pkg::ST_IDLE;
    endcase
  end

  // New state words from the feedback products.
  always_comb begin
    bv_ext = bqc_pkg::acc_t'(bv_r);
    d1_sum = bqc_pkg::round_coef((bv_ext <<< 1) - bqc_pkg::acc_t'(pa1_r))
             + bqc_pkg::acc_t'(d2_r);
    d2_sum = bqc_pkg::round_coef(bv_ext - bqc_pkg::acc_t'(pa2_r));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bqc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      coef_r      <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (coef_we) coef_r <= coef_wdata;
      if (commit) begin
        d1_r <= bqc_pkg::sat_sig(d1_sum);
        d2_r <= bqc_pkg::sat_sig(d2_sum);
      end
    end
  end

  // Datapath registers: the b0 multiply, the output sum, then both feedback multiplies.
  always_ff @(posedge clk) begin
    if (in_fire) v_r <= in_sig;
    if (state_r == bqc_pkg::ST_MUL_B) bv_r <= b0 * v_r;
    if (state_r == bqc_pkg::ST_SUM_Y) begin
      y_r <= bqc_pkg::sat_sig(bqc_pkg::round_coef(bqc_pkg::acc_t'(bv_r))
                              + bqc_pkg::acc_t'(d1_r));
    end
    if (state_r == bqc_pkg::ST_MUL_A) begin
      pa1_r <= a1 * y_r;
      pa2_r <= a2 * y_r;
    end
    if (commit) out_sig_r <= y_r;
  end

  assign out_valid = out_valid_r;
  assign out_sig   = out_sig_r;

  // Checks on the section sequencer.
  `ASSERT_NEXT(a_fire_starts, in_fire, state_r == bqc_pkg::ST_MUL_B, "request did not start")
  `ASSERT_NEXT(a_stall_holds, stalled, at_update && $stable(d1_r) && $stable(d2_r), "stall lost work")
  `ASSERT_NEXT(a_commit_valid, commit, out_valid_r && (out_sig_r == $past(y_r)), "result lost")
  `ASSERT_SAME(a_busy_no_take, busy, !in_ready && !commit, "busy section took a request")

endmodule

@@ rtl/biquad_cascade_lowpass.sv @@
// ----------------------------------------------------------------------------
// Biquad cascade low-pass filter
// Chain of biquad section cells; audio enters at the first, the last cell's
// output is rounded and saturated back to 16 bits.
// ----------------------------------------------------------------------------
// Each cell steps a request through a four-step sequence of multiply, sum,
// feedback multiply and state update, and can take a new request while it
// commits the last one, unless its output is stalled.
// Reset (synchronous, rst_n low) clears all state words, coefficients and
// valid flags; the output is zero until coefficients are written.
module biquad_cascade_lowpass (
  input  logic clk,
  input  logic rst_n,
  bqc_in_if.sink    in_chan,
  bqc_out_if.source out_chan,
  bqc_cfg_if.sink   cfg_chan
);

  localparam int N = bqc_pkg::NUM_SECTIONS;

  logic          link_valid [0:N];
  logic          link_ready [0:N];
  bqc_pkg::sig_t link_sig   [0:N];

  // Register writes are taken whenever the block is out of reset.
  assign cfg_chan.ready = rst_n;

  // Input sample scaled to the internal format.
  assign link_valid[0] = in_chan.valid;
  assign in_chan.ready = link_ready[0] && rst_n;
  assign link_sig[0]   = bqc_pkg::sig_t'(in_chan.audio_in) <<< bqc_pkg::IN_SHIFT;

  // Row of section cells.
  for (genvar s = 0; s < N; s++) begin : g_sect
    logic we;
    assign we = cfg_chan.valid &&
                (cfg_chan.index == bqc_pkg::CFG_IDX_W'(s));

    bqc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .coef_we    (we),
      .coef_wdata (cfg_chan.data),
      .in_valid   (link_valid[s]),
      .in_ready   (link_ready[s]),
      .in_sig     (link_sig[s]),
      .out_valid  (link_valid[s+1]),
      .out_ready  (link_ready[s+1]),
      .out_sig    (link_sig[s+1])
    );
  end

  // Final rounding and saturation to the audio format.
  assign out_chan.valid     = link_valid[N];
  assign link_ready[N]      = out_chan.ready;
  assign out_chan.audio_out = bqc_pkg::to_audio(link_sig[N]);

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Biquad cascade low-pass testbench
// Drives audio samples and coefficient writes into the three-section cascade
// and checks every filtered sample against a fixed-point model of the chain.
// Both channels idle and stall at random; one long output stall fills the
// pipeline.
// ----------------------------------------------------------------------------
module tb;

  // Register indexes of the coefficient port.
  localparam logic [bqc_pkg::CFG_IDX_W-1:0] REG_SECTION0     = bqc_pkg::CFG_IDX_W'(0);
  localparam logic [bqc_pkg::CFG_IDX_W-1:0] REG_SECTION1     = bqc_pkg::CFG_IDX_W'(1);
  localparam logic [bqc_pkg::CFG_IDX_W-1:0] REG_SECTION2     = bqc_pkg::CFG_IDX_W'(2);
  localparam logic [bqc_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
    bqc_pkg::CFG_IDX_W'(bqc_pkg::NUM_SECTIONS);
  localparam logic [bqc_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = {bqc_pkg::CFG_IDX_W{1'b1}};

  localparam int PIPE_LATENCY   = 5 * bqc_pkg::NUM_SECTIONS - 1;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 115;

  logic clk;
  logic rst_n;

  bqc_in_if  in_chan ();
  bqc_out_if out_chan ();
  bqc_cfg_if cfg_chan ();

  biquad_cascade_lowpass DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Filter model state: coefficient words and the two delay words per section.
  logic [bqc_pkg::CFG_W-1:0] coef_word [bqc_pkg::NUM_SECTIONS];
  longint                    z1_state  [bqc_pkg::NUM_SECTIONS];
  longint                    z2_state  [bqc_pkg::NUM_SECTIONS];

  bqc_pkg::audio_t expected_audio [$];

  int  bad_results  = 0;
  int  results_seen = 0;
  int  hold_left    = 0;
  int  stall_left   = 0;
  int  samples_sent;
  int  coef_writes;
  int  settings_used;
  bit  quiet;
  bit  hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturate to the signed 32-bit internal word.
  function automatic longint clamp_word(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Round half up and drop n fraction bits.
  function automatic longint round_drop(input longint x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Run one sample through all sections and update the delay words.
  function automatic bqc_pkg::audio_t lowpass_predict(input bqc_pkg::audio_t smp);
    bqc_pkg::coef_t b0;
    bqc_pkg::coef_t a1;
    bqc_pkg::coef_t a2;
    longint v;
    longint bv;
    longint y;
    longint n1;
    longint n2;
    longint o;
    v = longint'(smp) <<< bqc_pkg::IN_SHIFT;
    for (int k = 0; k < bqc_pkg::NUM_SECTIONS; k++) begin
      b0 = bqc_pkg::coef_t'(coef_word[k][bqc_pkg::B0_LSB +: bqc_pkg::COEF_W]);
      a1 = bqc_pkg::coef_t'(coef_word[k][bqc_pkg::A1_LSB +: bqc_pkg::COEF_W]);
      a2 = bqc_pkg::coef_t'(coef_word[k][bqc_pkg::A2_LSB +: bqc_pkg::COEF_W]);
      bv = longint'(b0) * v;
      y  = clamp_word(round_drop(bv, bqc_pkg::COEF_FRAC_BITS) + z1_state[k]);
      n1 = clamp_word(round_drop(2 * bv - longint'(a1) * y, bqc_pkg::COEF_FRAC_BITS)
                      + z2_state[k]);
      n2 = clamp_word(round_drop(bv - longint'(a2) * y, bqc_pkg::COEF_FRAC_BITS));
      z1_state[k] = n1;
      z2_state[k] = n2;
      v = y;
    end
    o = round_drop(v, bqc_pkg::IN_SHIFT);
    if (o > 32767) begin
      o = 32767;
    end else if (o < -32768) begin
      o = -32768;
    end
    return bqc_pkg::audio_t'(o);
  endfunction

  // Pack b0, a1 and a2 into one section word.
  function automatic logic [bqc_pkg::CFG_W-1:0] pack_coefs(input int b0, input int a1,
                                                           input int a2);
    return {bqc_pkg::coef_t'(a2), bqc_pkg::coef_t'(a1), bqc_pkg::coef_t'(b0)};
  endfunction

  // Sixth-order Butterworth at a twentieth of the sample rate, one section each.
  function automatic logic [bqc_pkg::CFG_W-1:0] butterworth_word(input int k);
    case (k)
      0: begin
        return pack_coefs(4940, -384006, 141623);
      end
      1: begin
        return pack_coefs(5265, -409211, 168124);
      end
      default: begin
        return pack_coefs(5940, -461700, 223318);
      end
    endcase
  endfunction

  // Coefficient word for one section: mostly stable poles, some raw or extreme.
  function automatic logic [bqc_pkg::CFG_W-1:0] pick_section_word(input int k);
    int unsigned r;
    int          a2;
    int          lim;
    int          a1;
    int          b0;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      a2  = $urandom_range(0, 249036);
      lim = 262144 + a2 - 4096;
      a1  = int'($urandom_range(0, 2 * lim)) - lim;
      b0  = int'($urandom_range(0, 16000)) - 8000;
      return pack_coefs(b0, a1, a2);
    end
    if (r < 7) begin
      return bqc_pkg::CFG_W'({$urandom, $urandom});
    end
    if (r == 7) begin
      return butterworth_word(k);
    end
    case ($urandom_range(0, 3))
      0: begin
        return {bqc_pkg::CFG_W{1'b1}};
      end
      1: begin
        return {3{20'h7FFFF}};
      end
      2: begin
        return {3{20'h80000}};
      end
      default: begin
        return '0;
      end
    endcase
  endfunction

  // Random audio: mostly full range, some extremes and some quiet signal.
  function automatic bqc_pkg::audio_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return bqc_pkg::audio_t'($urandom);
    end
    if (r < 8) begin
      case ($urandom_range(0, 4))
        0: begin
          return 16'sh7FFF;
        end
        1: begin
          return 16'sh8000;
        end
        2: begin
          return 16'sd1;
        end
        3: begin
          return -16'sd1;
        end
        default: begin
          return 16'sd0;
        end
      endcase
    end
    return bqc_pkg::audio_t'(int'($urandom_range(0, 512)) - 256);
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offer one sample; valid stays high after the request so bursts run back to back.
  task automatic send_sample(input bqc_pkg::audio_t smp);
    int              gap;
    bqc_pkg::audio_t pred;
    gap = idle_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.audio_in <= smp;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pred = lowpass_predict(smp);
    expected_audio = {expected_audio, pred};
    samples_sent++;
  endtask

  // Stop offering samples and wait for every pending result.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_audio.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the pipeline go fully idle before touching registers.
  task automatic settle();
    drain_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // Write one coefficient register.
  task automatic write_coefs(input logic [bqc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bqc_pkg::CFG_W-1:0] word);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= word;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    if (idx < bqc_pkg::NUM_SECTIONS) begin
      coef_word[idx] = word;
    end
    coef_writes++;
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_cascade(input logic [bqc_pkg::CFG_W-1:0] w0,
                                 input logic [bqc_pkg::CFG_W-1:0] w1,
                                 input logic [bqc_pkg::CFG_W-1:0] w2);
    settle();
    write_coefs(REG_SECTION0, w0);
    write_coefs(REG_SECTION1, w1);
    write_coefs(REG_SECTION2, w2);
    settings_used++;
  endtask

  task automatic set_quiet(input bit q);
    quiet <= q;
    @(posedge clk);
  endtask

  // With all coefficients zero after reset, every sample must come out as zero.
  task automatic test_reset_zero();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
  endtask

  // Writes to indexes past the last section must leave the cascade untouched.
  task automatic test_unused_index();
    settle();
    write_coefs(REG_FIRST_UNUSED, bqc_pkg::CFG_W'({$urandom, $urandom}));
    write_coefs(REG_LAST_UNUSED, {bqc_pkg::CFG_W{1'b1}});
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
  endtask

  // Real low-pass: full-scale steps, a flip of polarity and the smallest values.
  task automatic test_butterworth();
    program_cascade(butterworth_word(0), butterworth_word(1), butterworth_word(2));
    repeat (5) send_sample(16'sh7FFF);
    repeat (3) send_sample(16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd0);
  endtask

  // Extreme coefficients drive the state words and the output into saturation.
  task automatic test_saturation();
    program_cascade({20'h80000, 20'h80000, 20'h7FFFF}, {20'h80000, 20'h80000, 20'h7FFFF},
                    {20'h80000, 20'h80000, 20'h7FFFF});
    repeat (3) send_sample(16'sh7FFF);
    repeat (3) send_sample(16'sh8000);
  endtask

  // Random filters and samples; halfway through each phase the sender waits for
  // the pipeline to empty.
  task automatic test_random_filters();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        program_cascade(butterworth_word(0), butterworth_word(1), butterworth_word(2));
      end else begin
        program_cascade(pick_section_word(0), pick_section_word(1), pick_section_word(2));
      end
      set_quiet(p == 3);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (i == PHASE_SAMPLES / 2) begin
          drain_results();
        end
        send_sample(pick_sample());
      end
      set_quiet(1'b0);
    end
  endtask

  // Receiver holds off for a long stretch while samples keep coming back to back.
  task automatic test_backpressure();
    program_cascade(butterworth_word(0), butterworth_word(1), butterworth_word(2));
    set_quiet(1'b1);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (40) send_sample(pick_sample());
    set_quiet(1'b0);
  endtask

  // Result side: check each accepted sample and decide the next ready.
  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_audio.size() == 0) begin
        bad_results++;
        $display("%0t: unexpected audio_out, expected none, got %0d", $time,
                 out_chan.audio_out);
      end else begin
        bqc_pkg::audio_t exp_val;
        exp_val = expected_audio.pop_front();
        if (out_chan.audio_out !== exp_val) begin
          bad_results++;
          $display("%0t: audio_out mismatch, expected %0d, got %0d", $time, exp_val,
                   out_chan.audio_out);
        end
      end
    end
    if (hold_req) begin
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      stall_left = idle_len();
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no request moves on any channel for too long.
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.audio_in = '0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.index   = REG_SECTION0;
    cfg_chan.data    = '0;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    samples_sent     = 0;
    coef_writes      = 0;
    settings_used    = 0;
    for (int k = 0; k < bqc_pkg::NUM_SECTIONS; k++) begin
      coef_word[k] = '0;
      z1_state[k]  = 0;
      z2_state[k]  = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_zero();
    test_unused_index();
    test_butterworth();
    test_saturation();
    test_random_filters();
    test_backpressure();

    drain_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    $display("Ran %0d samples through %0d coefficient settings (%0d register writes),",
             samples_sent, settings_used, coef_writes);
    $display("checked %0d filtered samples, with random stalls and one long output hold.",
             results_seen);
    if (bad_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
